### design/cube_normal_texel_generator_macros.svh
// Assertion macros used by the cube normal texel generator back end.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef CUBE_NORMAL_TEXEL_GENERATOR_MACROS_SVH
`define CUBE_NORMAL_TEXEL_GENERATOR_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CNTG_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CNTG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/cntg_pkg.sv
// Shared types and constants for the cube normal texel generator.
// No dependencies; every RTL file of the block uses this package.
`default_nettype none

package cntg_pkg;

  // Cube geometry.
  localparam int CubeEdge = 128;
  localparam int Span     = (CubeEdge > 1) ? CubeEdge - 1 : 1;

  // Coordinate mapping: numerator width, reciprocal of the span, products.
  localparam int NumW  = 25;
  localparam int ProdW = NumW + 32;
  localparam int QW    = 18;
  localparam logic [31:0] DivRecip = 32'((64'd1 << 31) / Span);

  // Fixed-point one in Q1.16.
  localparam logic [QW-1:0] One = 18'd65536;

  // Dither generator constants.
  localparam logic [31:0] LcgSeed = 32'd23453425;
  localparam logic [31:0] LcgMul  = 32'd8923457;
  localparam logic [31:0] LcgAdd  = 32'd4937852;

  // Queue between front and back.
  localparam int QDepth = 2;
  localparam int QPtrW  = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int QCntW  = $clog2(QDepth + 1);

  // Face codes.
  localparam logic [2:0] FACE_POS_X = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_Y = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Z = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;

  // One classified texel: face code and Q1.16 coordinates (two's complement).
  typedef struct packed {
    logic [2:0]    face;
    logic [QW-1:0] w;
    logic [QW-1:0] h;
  } item_t;

  // Write side of the queue.
  typedef struct packed {
    logic  push;
    item_t item;
  } qwr_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_SUMSQ,
    B_SQRT,
    B_RECIP,
    B_SCALE,
    B_DITHER,
    B_ALPHA,
    B_DONE
  } back_state_t;

endpackage

`default_nettype wire

### design/cube_normal_texel_generator.sv
// Normalization cube map texel generator: top level (front, queue, back).
// From acceptance to result, 17 square root and 17 reciprocal steps dominate; texels with
// a positive z take extra alpha steps, and unused face codes skip normalization.
// Each end finishes one texel before it takes the next; the queue lies between them.
// Reset (synchronous, rst_n low) empties the queue and result register and
// reloads the dither generator with its seed.
`default_nettype none

module cube_normal_texel_generator (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic [2:0] in_face,
  input  wire logic [6:0] in_col,
  input  wire logic [6:0] in_row,
  output logic            in_full,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_red,
  output logic [7:0]      out_green,
  output logic [7:0]      out_blue,
  output logic [7:0]      out_alpha
);

  cntg_pkg::qwr_t  q_wr;
  cntg_pkg::item_t q_item;
  logic            q_full;
  logic            q_empty;
  logic            q_pop;

  // Front end: coordinate mapping.
  cntg_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_face (in_face),
    .in_col  (in_col),
    .in_row  (in_row),
    .in_full (in_full),
    .q_full  (q_full),
    .q_wr    (q_wr)
  );

  // Queue between the two ends.
  cntg_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .full    (q_full),
    .empty   (q_empty),
    .rd_item (q_item),
    .pop     (q_pop)
  );

  // Back end: normalization, dithering and alpha.
  cntg_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_red   (out_red),
    .out_green (out_green),
    .out_blue  (out_blue),
    .out_alpha (out_alpha)
  );

endmodule

`default_nettype wire

### design/cntg_front.sv
// Front end: accepts a texel transaction and maps column and row to Q1.16.
// Depends on cntg_pkg; feeds cntg_queue.
`default_nettype none

module cntg_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_push,
  input  wire logic [2:0]      in_face,
  input  wire logic [6:0]      in_col,
  input  wire logic [6:0]      in_row,
  output logic                 in_full,
  input  wire logic            q_full,
  output cntg_pkg::qwr_t       q_wr
);

  cntg_pkg::front_state_t state_r, state_nxt;
  logic [2:0] face_r, face_nxt;
  logic [6:0] col_r, col_nxt;
  logic [6:0] row_r, row_nxt;
  logic [cntg_pkg::ProdW-1:0] prodw_r, prodw_nxt;
  logic [cntg_pkg::ProdW-1:0] prodh_r, prodh_nxt;
  logic accept;

  // Numerator of the coordinate mapping: c * 2^17 + span / 2.
  function automatic logic [cntg_pkg::NumW-1:0] coord_num(input logic [6:0] c);
    return cntg_pkg::NumW'({c, 17'd0}) + cntg_pkg::NumW'(cntg_pkg::Span / 2);
  endfunction

  // Quotient estimate from the reciprocal product, one correction step,
  // then removal of the bias so that the result spans -1 to +1.
  function automatic logic [cntg_pkg::QW-1:0] coord_fix(
    input logic [6:0] c,
    input logic [cntg_pkg::ProdW-1:0] p
  );
    logic [cntg_pkg::NumW-1:0] num;
    logic [cntg_pkg::QW-1:0]   qe;
    logic [cntg_pkg::NumW-1:0] rem;
    logic [cntg_pkg::QW-1:0]   q;
    num = coord_num(c);
    qe  = p[31 +: cntg_pkg::QW];
    rem = num - cntg_pkg::NumW'(int'(qe) * cntg_pkg::Span);
    q   = (rem >= cntg_pkg::NumW'(cntg_pkg::Span)) ? qe + 1'b1 : qe;
    return q - cntg_pkg::One;
  endfunction

  // Clamp a column or row to the last texel of the edge.
  function automatic logic [6:0] clamp_coord(input logic [6:0] c);
    return (32'(c) > cntg_pkg::Span) ? 7'(cntg_pkg::Span) : c;
  endfunction

  assign accept = in_push && (state_r == cntg_pkg::F_IDLE);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cntg_pkg::F_IDLE: if (in_push) state_nxt = cntg_pkg::F_DIV;
      cntg_pkg::F_DIV:  state_nxt = cntg_pkg::F_PUSH;
      cntg_pkg::F_PUSH: if (!q_full) state_nxt = cntg_pkg::F_IDLE;
      default:          state_nxt = cntg_pkg::F_IDLE;
    endcase
  end

  // Outputs and datapath.
  always_comb begin
    face_nxt  = face_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    prodw_nxt = prodw_r;
    prodh_nxt = prodh_r;
    if (accept) begin
      face_nxt = in_face;
      col_nxt  = clamp_coord(in_col);
      row_nxt  = clamp_coord(in_row);
    end
    if (state_r == cntg_pkg::F_DIV) begin
      prodw_nxt = cntg_pkg::ProdW'(coord_num(col_r)) * cntg_pkg::ProdW'(cntg_pkg::DivRecip);
      prodh_nxt = cntg_pkg::ProdW'(coord_num(row_r)) * cntg_pkg::ProdW'(cntg_pkg::DivRecip);
    end
    in_full        = (state_r != cntg_pkg::F_IDLE);
    q_wr.push      = (state_r == cntg_pkg::F_PUSH) && !q_full;
    q_wr.item.face = face_r;
    q_wr.item.w    = coord_fix(col_r, prodw_r);
    q_wr.item.h    = coord_fix(row_r, prodh_r);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cntg_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    face_r  <= face_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
    prodw_r <= prodw_nxt;
    prodh_r <= prodh_nxt;
  end

endmodule

`default_nettype wire

### design/cntg_queue.sv
// Short queue of classified texels between the front and back ends.
// Depends on cntg_pkg.
`default_nettype none

module cntg_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cntg_pkg::qwr_t wr,
  output logic                full,
  output logic                empty,
  output cntg_pkg::item_t     rd_item,
  input  wire logic           pop
);

  cntg_pkg::item_t mem_r [cntg_pkg::QDepth];
  logic [cntg_pkg::QPtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [cntg_pkg::QPtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [cntg_pkg::QCntW-1:0] cnt_r, cnt_nxt;
  logic do_push, do_pop;

  function automatic logic [cntg_pkg::QPtrW-1:0] ptr_inc(
    input logic [cntg_pkg::QPtrW-1:0] p
  );
    return (p == cntg_pkg::QPtrW'(cntg_pkg::QDepth - 1)) ? '0 : p + 1'b1;
  endfunction

  // Status and pointer updates.
  always_comb begin
    full       = (cnt_r == cntg_pkg::QCntW'(cntg_pkg::QDepth));
    empty      = (cnt_r == '0);
    do_push    = wr.push && !full;
    do_pop     = pop && !empty;
    wr_ptr_nxt = do_push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    cnt_nxt    = cnt_r + cntg_pkg::QCntW'(do_push) - cntg_pkg::QCntW'(do_pop);
    rd_item    = mem_r[rd_ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= wr.item;
  end

endmodule

`default_nettype wire

### design/cntg_back.sv
// Back end: normalizes the face vector, dithers the colors, computes alpha.
// Depends on cntg_pkg and the assertion macro header; reads cntg_queue.
`default_nettype none
`include "cube_normal_texel_generator_macros.svh"

module cntg_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_empty,
  input  wire cntg_pkg::item_t q_item,
  output logic                 q_pop,
  output logic                 out_empty,
  input  wire logic            out_pop,
  output logic [7:0]           out_red,
  output logic [7:0]           out_green,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_alpha
);

  cntg_pkg::back_state_t state_r, state_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [17:0] v_r [3];
  logic [17:0] v_nxt [3];
  logic [17:0] n_r [3];
  logic [17:0] n_nxt [3];
  logic [7:0]  col_r [3];
  logic [7:0]  col_nxt [3];
  logic [33:0] acc_r, acc_nxt;
  logic [34:0] res_r, res_nxt;
  logic [16:0] div_r, div_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [17:0] z_r, z_nxt;
  logic [7:0]  alpha_r, alpha_nxt;
  logic [31:0] lcg_r, lcg_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  ored_r, ogreen_r, oblue_r, oalpha_r;
  logic        out_load;
  logic        face_ok;
  logic        n2_pos;
  logic [1:0]  idx;
  logic [1:0]  cidx;
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  logic [34:0] bitv, trial;
  logic [17:0] sh;
  logic        ge;
  logic [34:0] rnd;
  logic [17:0] nm;
  logic [15:0] dk;
  logic [17:0] nx;
  logic [25:0] cval;
  logic [25:0] aval;

  // Magnitude of a Q1.16 component.
  function automatic logic [16:0] mag(input logic [17:0] x);
    return x[17] ? 17'(-x) : 17'(x);
  endfunction

  assign idx     = cnt_r[1:0];
  assign cidx    = 2'(cnt_r - 5'd1);
  assign face_ok = (q_item.face <= cntg_pkg::FACE_NEG_Z);
  assign n2_pos  = !n_r[2][17] && (n_r[2] != '0);
  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign out_load = (state_r == cntg_pkg::B_DONE) && (!out_valid_r || out_pop);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      cntg_pkg::B_IDLE:
        if (!q_empty) state_nxt = face_ok ? cntg_pkg::B_SUMSQ : cntg_pkg::B_DITHER;
      cntg_pkg::B_SUMSQ:
        if (cnt_r == 5'd2) state_nxt = cntg_pkg::B_SQRT;
      cntg_pkg::B_SQRT:
        if (cnt_r == 5'd0) state_nxt = cntg_pkg::B_RECIP;
      cntg_pkg::B_RECIP:
        if (cnt_r == 5'd0) state_nxt = cntg_pkg::B_SCALE;
      cntg_pkg::B_SCALE:
        if (cnt_r == 5'd2) state_nxt = cntg_pkg::B_DITHER;
      cntg_pkg::B_DITHER:
        if (cnt_r == 5'd3) state_nxt = n2_pos ? cntg_pkg::B_ALPHA : cntg_pkg::B_DONE;
      cntg_pkg::B_ALPHA:
        if (cnt_r == 5'd3) state_nxt = cntg_pkg::B_DONE;
      cntg_pkg::B_DONE:
        if (out_load) state_nxt = cntg_pkg::B_IDLE;
      default:
        state_nxt = cntg_pkg::B_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    cnt_nxt   = cnt_r;
    v_nxt     = v_r;
    n_nxt     = n_r;
    col_nxt   = col_r;
    acc_nxt   = acc_r;
    res_nxt   = res_r;
    div_nxt   = div_r;
    quo_nxt   = quo_r;
    z_nxt     = z_r;
    alpha_nxt = alpha_r;
    lcg_nxt   = lcg_r;
    mul_a     = '0;
    mul_b     = '0;
    q_pop     = 1'b0;
    bitv      = 35'd1 << {cnt_r, 1'b0};
    trial     = res_r + bitv;
    sh        = {div_r, 1'b0};
    ge        = (sh >= {1'b0, res_r[16:0]});
    rnd       = '0;
    nm        = '0;
    dk        = lcg_r[23:8];
    nx        = n_r[cidx] + cntg_pkg::One;
    cval      = {1'b0, nx, 7'b0} - 26'(nx) + 26'(dk) + 26'(dk[15]);
    aval      = {z_r, 8'b0} - 26'(z_r);

    case (state_r)
      // Take a texel and build its face vector.
      cntg_pkg::B_IDLE: begin
        q_pop   = !q_empty;
        cnt_nxt = '0;
        acc_nxt = '0;
        for (int i = 0; i < 3; i++) begin
          n_nxt[i] = '0;
          v_nxt[i] = '0;
        end
        case (q_item.face)
          cntg_pkg::FACE_POS_X: begin
            v_nxt[0] = cntg_pkg::One;  v_nxt[1] = -q_item.h;     v_nxt[2] = -q_item.w;
          end
          cntg_pkg::FACE_NEG_X: begin
            v_nxt[0] = -cntg_pkg::One; v_nxt[1] = -q_item.h;     v_nxt[2] = q_item.w;
          end
          cntg_pkg::FACE_POS_Y: begin
            v_nxt[0] = q_item.w;       v_nxt[1] = cntg_pkg::One; v_nxt[2] = q_item.h;
          end
          cntg_pkg::FACE_NEG_Y: begin
            v_nxt[0] = q_item.w;       v_nxt[1] = -cntg_pkg::One; v_nxt[2] = -q_item.h;
          end
          cntg_pkg::FACE_POS_Z: begin
            v_nxt[0] = q_item.w;       v_nxt[1] = -q_item.h;     v_nxt[2] = cntg_pkg::One;
          end
          cntg_pkg::FACE_NEG_Z: begin
            v_nxt[0] = -q_item.w;      v_nxt[1] = -q_item.h;     v_nxt[2] = -cntg_pkg::One;
          end
          default: ;
        endcase
      end

      // Sum of squares, one component per cycle.
      cntg_pkg::B_SUMSQ: begin
        mul_a   = 32'(mag(v_r[idx]));
        mul_b   = 32'(mag(v_r[idx]));
        acc_nxt = acc_r + mul_p[33:0];
        cnt_nxt = (cnt_r == 5'd2) ? 5'd16 : cnt_r + 5'd1;
        res_nxt = '0;
      end

      // Integer square root, one result bit per cycle.
      cntg_pkg::B_SQRT: begin
        if ({1'b0, acc_r} >= trial) begin
          acc_nxt = acc_r - trial[33:0];
          res_nxt = (res_r >> 1) + bitv;
        end else begin
          res_nxt = res_r >> 1;
        end
        if (cnt_r == 5'd0) begin
          cnt_nxt = 5'd16;
          // The upper quotient bits of 2^32 / root are zero because the root
          // is at least 2^16; only the low 17 bits are developed.
          div_nxt = 17'd32768;
          quo_nxt = '0;
        end else begin
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      // Restoring division of 2^32 by the root.
      cntg_pkg::B_RECIP: begin
        div_nxt = ge ? 17'(sh - {1'b0, res_r[16:0]}) : sh[16:0];
        quo_nxt = {quo_r[15:0], ge};
        cnt_nxt = (cnt_r == 5'd0) ? 5'd0 : cnt_r - 5'd1;
      end

      // Scale each component by the reciprocal, rounding the magnitude.
      cntg_pkg::B_SCALE: begin
        mul_a      = 32'(mag(v_r[idx]));
        mul_b      = 32'(quo_r);
        rnd        = 35'(mul_p[33:0]) + 35'd32768;
        nm         = 18'(rnd[34:16]);
        n_nxt[idx] = v_r[idx][17] ? -nm : nm;
        cnt_nxt    = (cnt_r == 5'd2) ? 5'd0 : cnt_r + 5'd1;
      end

      // Step the dither generator three times; each color trails its step.
      cntg_pkg::B_DITHER: begin
        if (cnt_r != 5'd3) begin
          mul_a   = lcg_r;
          mul_b   = cntg_pkg::LcgMul;
          lcg_nxt = mul_p[31:0] + cntg_pkg::LcgAdd;
        end
        if (cnt_r != 5'd0) begin
          col_nxt[cidx] = (cval[25:16] > 10'd255) ? 8'd255 : cval[23:16];
        end
        cnt_nxt   = (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
        z_nxt     = n_r[2];
        alpha_nxt = '0;
      end

      // Raise z to the eighth power by repeated rounded squaring.
      cntg_pkg::B_ALPHA: begin
        if (cnt_r != 5'd3) begin
          mul_a = 32'(z_r);
          mul_b = 32'(z_r);
          rnd   = 35'(mul_p[33:0]) + 35'd32768;
          z_nxt = 18'(rnd[34:16]);
        end else begin
          alpha_nxt = (aval[25:16] > 10'd255) ? 8'd255 : aval[23:16];
        end
        cnt_nxt = (cnt_r == 5'd3) ? 5'd0 : cnt_r + 5'd1;
      end

      default: ;
    endcase

    out_valid_nxt = out_load ? 1'b1 : (out_pop ? 1'b0 : out_valid_r);
    out_empty     = !out_valid_r;
    out_red       = ored_r;
    out_green     = ogreen_r;
    out_blue      = oblue_r;
    out_alpha     = oalpha_r;
  end

  // Control state and the dither generator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= cntg_pkg::B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      lcg_r       <= cntg_pkg::LcgSeed;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      lcg_r       <= lcg_nxt;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk) begin
    v_r     <= v_nxt;
    n_r     <= n_nxt;
    col_r   <= col_nxt;
    acc_r   <= acc_nxt;
    res_r   <= res_nxt;
    div_r   <= div_nxt;
    quo_r   <= quo_nxt;
    z_r     <= z_nxt;
    alpha_r <= alpha_nxt;
    if (out_load) begin
      ored_r   <= col_r[0];
      ogreen_r <= col_r[1];
      oblue_r  <= col_r[2];
      oalpha_r <= alpha_r;
    end
  end

  // The root of a valid face vector lies between 2^16 and 2^17.
  `CNTG_ASSERT_IMPL(a_root_range, state_r == cntg_pkg::B_SCALE, res_r[16] && (res_r[34:17] == '0), "square root out of range")
  // The dither generator moves only while colors are being produced.
  `CNTG_ASSERT_NEXT(a_lcg_hold, state_r != cntg_pkg::B_DITHER, $stable(lcg_r), "dither generator stepped outside the dither phase")
  // The dither step counter never exceeds three.
  `CNTG_ASSERT_IMPL(a_dither_count, state_r == cntg_pkg::B_DITHER, cnt_r <= 5'd3, "dither step counter overran")

endmodule

`default_nettype wire

### sim/cntg_checker.sv
// Checker for the cube normal texel generator: watches the input and output ports,
// predicts each texel from the face, column and row, and counts mismatches.
// Depends on cntg_pkg for the face codes and the dither generator constants.
module cntg_checker (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire logic [2:0] in_face,
  input  wire logic [6:0] in_col,
  input  wire logic [6:0] in_row,
  input  wire logic       out_empty,
  input  wire logic       out_pop,
  input  wire logic [7:0] out_red,
  input  wire logic [7:0] out_green,
  input  wire logic [7:0] out_blue,
  input  wire logic [7:0] out_alpha,
  output int              errors,
  output int              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } texel_t;

  texel_t      texel_q[$];
  logic [31:0] lcg;

  // Maps a texel index to a Q1.16 coordinate in [-1,1].
  function automatic longint to_coord(input logic [6:0] c);
    longint cc;
    longint span;
    span = (cntg_pkg::CubeEdge > 1) ? cntg_pkg::CubeEdge - 1 : 1;
    cc = (c > span) ? span : c;
    return (cc * 131072 + span / 2) / span - 65536;
  endfunction

  // Integer square root by the bitwise method.
  function automatic longint int_sqrt(input longint v);
    longint res;
    longint b;
    res = 0;
    b = 64'sd1 << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // Advances the dither generator and returns the centered Q.16 dither.
  function automatic longint next_dither();
    longint k;
    lcg = lcg * cntg_pkg::LcgMul + cntg_pkg::LcgAdd;
    k = (lcg >> 8) & 32'hffff;
    return k + ((k >= 32768) ? 1 : 0) - 32768;
  endfunction

  function automatic logic [7:0] biased_color(input longint n, input longint d);
    longint v;
    v = (n + 65536) * 127 + d + 32768;
    if (v < 0) return 8'd0;
    v = v >>> 16;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic longint sq16(input longint a);
    return (a * a + 32768) >>> 16;
  endfunction

  // Computes the expected texel and advances the dither state.
  function automatic texel_t predict_texel(input logic [2:0] face, input logic [6:0] col,
                                           input logic [6:0] row);
    longint w, h, s, q, r, m, z8, al;
    longint v[3];
    longint n[3];
    texel_t t;
    w = to_coord(col);
    h = to_coord(row);
    v[0] = 0; v[1] = 0; v[2] = 0;
    n[0] = 0; n[1] = 0; n[2] = 0;
    case (face)
      cntg_pkg::FACE_POS_X: begin v[0] = 65536;  v[1] = -h;     v[2] = -w;     end
      cntg_pkg::FACE_NEG_X: begin v[0] = -65536; v[1] = -h;     v[2] = w;      end
      cntg_pkg::FACE_POS_Y: begin v[0] = w;      v[1] = 65536;  v[2] = h;      end
      cntg_pkg::FACE_NEG_Y: begin v[0] = w;      v[1] = -65536; v[2] = -h;     end
      cntg_pkg::FACE_POS_Z: begin v[0] = w;      v[1] = -h;     v[2] = 65536;  end
      cntg_pkg::FACE_NEG_Z: begin v[0] = -w;     v[1] = -h;     v[2] = -65536; end
      default: ;
    endcase
    s = v[0] * v[0] + v[1] * v[1] + v[2] * v[2];
    if (s > 0) begin
      q = int_sqrt(s);
      r = (q != 0) ? (64'sd1 <<< 32) / q : 0;
      for (int i = 0; i < 3; i++) begin
        m = (v[i] < 0) ? -v[i] : v[i];
        m = (m * r + 32768) >>> 16;
        n[i] = (v[i] < 0) ? -m : m;
      end
    end
    t.red   = biased_color(n[0], next_dither());
    t.green = biased_color(n[1], next_dither());
    t.blue  = biased_color(n[2], next_dither());
    al = 0;
    if (n[2] > 0) begin
      z8 = sq16(sq16(sq16(n[2])));
      al = (z8 * 255) >>> 16;
      if (al > 255) al = 255;
    end
    t.alpha = al[7:0];
    return t;
  endfunction

  // Predict on each accepted input transaction, compare on each output transaction.
  always @(posedge clk) begin
    texel_t want;
    if (!rst_n) begin
      lcg = cntg_pkg::LcgSeed;
      texel_q.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (in_push && !in_full) texel_q.push_back(predict_texel(in_face, in_col, in_row));
      if (out_pop && !out_empty) begin
        if (texel_q.size() == 0) begin
          $display("%0t: unexpected texel r=%0d g=%0d b=%0d a=%0d", $time,
                   out_red, out_green, out_blue, out_alpha);
          errors <= errors + 1;
        end else begin
          want = texel_q.pop_front();
          if (want != {out_red, out_green, out_blue, out_alpha}) begin
            $write("%0t: texel mismatch expected r=%0d g=%0d b=%0d a=%0d,",
                   $time, want.red, want.green, want.blue, want.alpha);
            $display(" got r=%0d g=%0d b=%0d a=%0d",
                     out_red, out_green, out_blue, out_alpha);
            errors <= errors + 1;
          end
        end
      end
      pending <= texel_q.size();
    end
  end
endmodule

### sim/testbench.sv
// Top of the cube normal texel generator testbench: clock, reset, stimulus, verdict.
// Depends on the block's RTL, cntg_pkg and the cntg_checker module.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk;
  logic       rst_n;
  logic       in_push;
  logic [2:0] in_face;
  logic [6:0] in_col;
  logic [6:0] in_row;
  logic       in_full;
  logic       out_empty;
  logic       out_pop;
  logic [7:0] out_red, out_green, out_blue, out_alpha;
  int         errors;
  int         pending;
  int         send_idle;
  int         recv_stall;
  int         hold_cycles;
  longint     cycle_count;

  cube_normal_texel_generator i_dut (.*);

  cntg_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  initial begin
    out_pop = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_pop <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else begin
        out_pop <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // Watchdog on the cycle count.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("[cube_normal_texel_generator] ERROR");
        $finish;
      end
    end
  end

  // Offers one input transaction and waits until it is accepted; push stays
  // high afterwards so that the next transaction can follow directly.
  task automatic send_texel(input logic [2:0] face, input logic [6:0] col,
                            input logic [6:0] row);
    while ($urandom_range(99) < send_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_face <= face;
    in_col  <= col;
    in_row  <= row;
    @(posedge clk);
    while (in_full) @(posedge clk);
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic wait_drained();
    in_push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mostly valid faces, sometimes the unused codes; coordinates often at edges.
  function automatic logic [6:0] pick_coord();
    case ($urandom_range(5))
      0: return 7'd0;
      1: return 7'd127;
      default: return 7'($urandom_range(127));
    endcase
  endfunction

  task automatic random_phase(input int count, input int idle, input int stall);
    logic [2:0] face;
    send_idle  = idle;
    recv_stall = stall;
    for (int i = 0; i < count; i++) begin
      face = ($urandom_range(9) == 0) ? 3'($urandom_range(7)) : 3'($urandom_range(5));
      send_texel(face, pick_coord(), pick_coord());
    end
  endtask

  initial begin
    int face_code;
    rst_n       = 1'b0;
    in_push     = 1'b0;
    in_face     = '0;
    in_col      = '0;
    in_row      = '0;
    send_idle   = 0;
    recv_stall  = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: every face code, including the unused ones, at two corners, then the +Z center and other chosen texels.
    for (face_code = 0; face_code < 8; face_code++) begin
      send_texel(3'(face_code), 7'd0, 7'd127);
      send_texel(3'(face_code), 7'd127, 7'd0);
    end
    send_texel(cntg_pkg::FACE_POS_Z, 7'd64, 7'd63);
    send_texel(cntg_pkg::FACE_POS_Z, 7'd0, 7'd0);
    send_texel(cntg_pkg::FACE_NEG_Z, 7'd127, 7'd127);
    send_texel(cntg_pkg::FACE_POS_X, 7'h55, 7'h2a);
    send_texel(cntg_pkg::FACE_NEG_Y, 7'h2a, 7'h55);
    wait_drained();

    random_phase(300, 0, 0);
    random_phase(300, 56, 0);
    // Long receiver hold-off while the sender keeps going.
    hold_cycles = 400;
    random_phase(300, 0, 56);
    // Sender pauses until everything has come out.
    wait_drained();
    random_phase(330, 10, 10);

    wait_drained();
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("[cube_normal_texel_generator] OK");
    end else begin
      $display("[cube_normal_texel_generator] ERROR");
    end
    $finish;
  end
endmodule
